/* design/bbr_pkg.sv */
// shared types and constants for the msb-first bitstream bit reader
package bbr_pkg;

  localparam int BUFFER_BITS = 64;
  localparam int FILL_W = $clog2(BUFFER_BITS + 1);
  localparam int COUNT_W = 6;
  localparam int VALUE_W = 32;
  localparam int AVAIL_W = 7;

  localparam logic [2:0] REQ_RESTART    = 3'd0;
  localparam logic [2:0] REQ_PUSH       = 3'd1;
  localparam logic [2:0] REQ_GET        = 3'd2;
  localparam logic [2:0] REQ_PEEK       = 3'd3;
  localparam logic [2:0] REQ_PEEK_ALIGN = 3'd4;
  localparam logic [2:0] REQ_PEEK_AFTER = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EOD     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BAD     = 3'd3;
  localparam logic [2:0] ST_STARVED = 3'd4;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(VALUE_W);

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         data_byte;
    logic               end_of_frame;
    logic [COUNT_W-1:0] bit_count;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [3:0]         peeked_count;
    logic [2:0]         status;
    logic [AVAIL_W-1:0] bits_available;
  } rsp_t;

endpackage

/* design/bbr_core.sv */
// bit buffer state and combinational request evaluation
module bbr_core import bbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req,
  output rsp_t rsp
);

  logic [BUFFER_BITS-1:0] bit_buffer, bit_buffer_next;
  logic [FILL_W-1:0]      fill_count, fill_count_next;
  logic                   frame_ended, frame_ended_next;
  logic                   eof_flag, eof_flag_next;

  logic [3:0]             align;
  logic [COUNT_W-1:0]     want;
  logic [COUNT_W-1:0]     keep;
  logic [FILL_W-1:0]      want_f;
  logic [FILL_W-1:0]      fill_left;
  logic [FILL_W:0]        push_sum;
  logic [BUFFER_BITS-1:0] shifted;
  logic [VALUE_W-1:0]     keep_mask;
  logic [VALUE_W-1:0]     value;
  logic [3:0]             peeked;
  logic [2:0]             status;

  always_comb begin
    bit_buffer_next  = bit_buffer;
    fill_count_next  = fill_count;
    frame_ended_next = frame_ended;
    eof_flag_next    = eof_flag;
    value            = '0;
    peeked           = 4'd0;
    status           = ST_OK;
    want             = '0;
    keep             = '0;
    align            = (fill_count[2:0] == 3'd0) ? 4'd8 : {1'b0, fill_count[2:0]};
    push_sum         = {1'b0, fill_count} + (FILL_W + 1)'(8);

    // operand selection for the read types
    if (req.req_type == REQ_PEEK_ALIGN) begin
      want   = COUNT_W'(align);
      keep   = COUNT_W'(align);
      peeked = align;
    end else if (req.bit_count > MAX_COUNT) begin
      want = '0;
    end else if (req.req_type == REQ_PEEK_AFTER) begin
      keep = req.bit_count;
      want = (req.bit_count == '0) ? '0 : req.bit_count + COUNT_W'(align);
    end else begin
      want = req.bit_count;
      keep = req.bit_count;
    end
    want_f    = FILL_W'(want);
    fill_left = fill_count - want_f;

    // oldest bits to the bottom, zero padded when short
    if (want_f <= fill_count) begin
      shifted = bit_buffer >> fill_left;
    end else begin
      shifted = bit_buffer << (want_f - fill_count);
    end
    keep_mask = (keep >= MAX_COUNT) ? '1 : ((VALUE_W'(1) << keep) - VALUE_W'(1));

    case (req.req_type)
      REQ_RESTART: begin
        bit_buffer_next  = '0;
        fill_count_next  = '0;
        frame_ended_next = 1'b0;
        eof_flag_next    = 1'b0;
      end
      REQ_PUSH: begin
        if (push_sum > (FILL_W + 1)'(BUFFER_BITS)) begin
          status = ST_FULL;
        end else begin
          bit_buffer_next = {bit_buffer[BUFFER_BITS-9:0], req.data_byte};
          fill_count_next = FILL_W'(push_sum);
        end
        if (req.end_of_frame) begin
          frame_ended_next = 1'b1;
        end
      end
      REQ_GET, REQ_PEEK, REQ_PEEK_ALIGN, REQ_PEEK_AFTER: begin
        if (req.req_type != REQ_PEEK_ALIGN && req.bit_count > MAX_COUNT) begin
          status = ST_BAD;
        end else if (eof_flag) begin
          status = ST_EOD;
        end else if (want == '0) begin
          value = '0;
        end else if (want_f <= fill_count) begin
          value = shifted[VALUE_W-1:0] & keep_mask;
          if (req.req_type == REQ_GET) begin
            fill_count_next = fill_left;
            bit_buffer_next = bit_buffer & ~({BUFFER_BITS{1'b1}} << fill_left);
          end
        end else if (!frame_ended) begin
          status = ST_STARVED;
        end else if (req.req_type == REQ_GET) begin
          bit_buffer_next = '0;
          fill_count_next = '0;
          eof_flag_next   = 1'b1;
          status          = ST_EOD;
        end else begin
          value = shifted[VALUE_W-1:0] & keep_mask;
        end
      end
      default: begin
        status = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer  <= '0;
      fill_count  <= '0;
      frame_ended <= 1'b0;
      eof_flag    <= 1'b0;
    end else if (take) begin
      bit_buffer  <= bit_buffer_next;
      fill_count  <= fill_count_next;
      frame_ended <= frame_ended_next;
      eof_flag    <= eof_flag_next;
    end
  end

  assign rsp.value          = value;
  assign rsp.peeked_count   = peeked;
  assign rsp.status         = status;
  assign rsp.bits_available = AVAIL_W'(fill_count_next);

endmodule

/* design/bitstream_bit_reader_top.sv */
// top level of the msb-first bitstream bit reader with registered result stage
// a result is registered at its request transfer, into the skid entry when a result waits
// throughput: one request per cycle while req_stall is low; buffer update and shift are combinational
// a two-entry result stage lets a request transfer while one result waits
// rst (synchronous) empties the bit buffer, clears both frame flags and drops pending results
module bitstream_bit_reader_top import bbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  rsp_t core_rsp;
  rsp_t skid;
  logic skid_valid;
  logic req_take;
  logic rsp_take;

  assign req_stall = skid_valid;
  assign req_take  = req_valid & ~req_stall;
  assign rsp_take  = rsp_valid & ~rsp_stall;

  bbr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (req_take),
    .req  (req),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (rsp_take) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= req_take;
        end
      end else if (req_take) begin
        if (rsp_valid) begin
          skid_valid <= 1'b1;
        end else begin
          rsp_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      if (skid_valid) begin
        rsp <= skid;
      end else if (req_take) begin
        rsp <= core_rsp;
      end
    end else if (req_take) begin
      if (rsp_valid) begin
        skid <= core_rsp;
      end else begin
        rsp <= core_rsp;
      end
    end
  end

endmodule

/* dv/testbench.sv */
// testbench for the msb-first bitstream bit reader, checked against a predictor
`timescale 1ns / 100ps

module testbench;
  import bbr_pkg::*;

  localparam logic [2:0] REQ_RSVD_A = 3'd6;
  localparam logic [2:0] REQ_RSVD_B = 3'd7;
  localparam int TAIL_CYCLES = 4;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // predicted reader state
  logic [127:0] pred_bits = '0;
  int unsigned pred_fill = 0;
  bit pred_ended = 1'b0;
  bit pred_eod = 1'b0;

  rsp_t pending_rsp[$];
  rsp_t want_rsp;
  int errors = 0;
  int req_count = 0;
  int rsp_count = 0;
  int status_hits[8];
  int quiet_cycles = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int unsigned stim_fill = 0;

  bitstream_bit_reader_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [127:0] low_ones(int unsigned k);
    return (128'd1 << k) - 128'd1;
  endfunction

  function automatic int unsigned align_span();
    return (pred_fill % 8 == 0) ? 8 : pred_fill % 8;
  endfunction

  // oldest bits of the stream, right aligned, zeros where the stream runs short
  function automatic logic [127:0] oldest_window(int unsigned want);
    if (want <= pred_fill) return pred_bits >> (pred_fill - want);
    return pred_bits << (want - pred_fill);
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int unsigned n;
    int unsigned want;
    int unsigned keep;
    o = '0;
    n = r.bit_count;
    want = 0;
    keep = 0;
    case (r.req_type)
      REQ_RESTART: begin
        pred_bits = '0;
        pred_fill = 0;
        pred_ended = 1'b0;
        pred_eod = 1'b0;
      end
      REQ_PUSH: begin
        if (pred_fill + 8 > BUFFER_BITS) begin
          o.status = ST_FULL;
        end else begin
          pred_bits = {pred_bits[119:0], r.data_byte};
          pred_fill += 8;
        end
        if (r.end_of_frame) pred_ended = 1'b1;
      end
      REQ_GET, REQ_PEEK, REQ_PEEK_ALIGN, REQ_PEEK_AFTER: begin
        if (r.req_type == REQ_PEEK_ALIGN) begin
          want = align_span();
          keep = want;
          o.peeked_count = 4'(want);
        end else if (n > VALUE_W) begin
          o.status = ST_BAD;
        end else if (r.req_type == REQ_PEEK_AFTER) begin
          keep = n;
          want = (n == 0) ? 0 : n + align_span();
        end else begin
          want = n;
          keep = n;
        end
        if (o.status == ST_OK) begin
          if (pred_eod) begin
            o.status = ST_EOD;
          end else if (want == 0) begin
            o.value = '0;
          end else if (want <= pred_fill) begin
            o.value = 32'(oldest_window(want) & low_ones(keep));
            if (r.req_type == REQ_GET) begin
              pred_fill -= want;
              pred_bits &= low_ones(pred_fill);
            end
          end else if (!pred_ended) begin
            o.status = ST_STARVED;
          end else if (r.req_type == REQ_GET) begin
            pred_bits = '0;
            pred_fill = 0;
            pred_eod = 1'b1;
            o.status = ST_EOD;
          end else begin
            o.value = 32'(oldest_window(want) & low_ones(keep));
          end
        end
      end
      default: o.status = ST_BAD;
    endcase
    o.bits_available = 7'(pred_fill);
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
      errors++;
    end
  endtask

  // result check, then prediction of the request taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsp_count++;
        if (pending_rsp.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h", $time, rsp);
          errors++;
        end else begin
          want_rsp = pending_rsp.pop_front();
          status_hits[want_rsp.status]++;
          check_field("value", want_rsp.value, rsp.value);
          check_field("peeked_count", 32'(want_rsp.peeked_count), 32'(rsp.peeked_count));
          check_field("status", 32'(want_rsp.status), 32'(rsp.status));
          check_field("bits_available", 32'(want_rsp.bits_available),
                      32'(rsp.bits_available));
        end
      end
      if (req_valid && !req_stall) begin
        req_count++;
        pending_rsp.push_back(predict_response(req));
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench failed");
    $finish;
  end

  function automatic req_t make_req(logic [2:0] kind, logic [7:0] data, logic eof,
                                    logic [COUNT_W-1:0] count);
    req_t r;
    r.req_type = kind;
    r.data_byte = data;
    r.end_of_frame = eof;
    r.bit_count = count;
    return r;
  endfunction

  task automatic issue_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_results_done();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  function automatic req_t random_req();
    req_t r;
    int unsigned pick;
    int unsigned push_pct;
    int unsigned sub;
    r.data_byte = 8'($urandom_range(255));
    r.end_of_frame = ($urandom_range(99) < 4);
    r.bit_count = ($urandom_range(99) < 8) ? COUNT_W'($urandom_range(63, 33))
                                           : COUNT_W'($urandom_range(32));
    push_pct = (stim_fill < 32) ? 50 : 30;
    pick = $urandom_range(99);
    if (pick < 2) begin
      r.req_type = REQ_RESTART;
      stim_fill = 0;
    end else if (pick < 4) begin
      r.req_type = $urandom_range(1) ? REQ_RSVD_A : REQ_RSVD_B;
    end else if (pick < 4 + push_pct) begin
      r.req_type = REQ_PUSH;
      if (stim_fill + 8 <= BUFFER_BITS) stim_fill += 8;
    end else begin
      sub = $urandom_range(99);
      if (sub < 40) begin
        r.req_type = REQ_GET;
        if (r.bit_count <= VALUE_W)
          stim_fill = (r.bit_count > stim_fill) ? 0 : stim_fill - r.bit_count;
      end else if (sub < 65) begin
        r.req_type = REQ_PEEK;
      end else if (sub < 80) begin
        r.req_type = REQ_PEEK_ALIGN;
      end else begin
        r.req_type = REQ_PEEK_AFTER;
      end
    end
    return r;
  endfunction

  task automatic test_empty_and_bad();
    issue_request(make_req(REQ_GET, 8'h00, 1'b0, 6'd8));
    issue_request(make_req(REQ_PEEK_ALIGN, 8'hff, 1'b1, 6'd63));
    issue_request(make_req(REQ_RSVD_A, 8'h00, 1'b0, 6'd1));
    issue_request(make_req(REQ_RSVD_B, 8'hff, 1'b1, 6'd32));
    issue_request(make_req(REQ_GET, 8'h00, 1'b0, 6'd33));
    issue_request(make_req(REQ_PEEK, 8'h00, 1'b0, 6'd63));
    issue_request(make_req(REQ_PEEK_AFTER, 8'h00, 1'b0, 6'd40));
    wait_results_done();
  endtask

  task automatic test_fill_and_read();
    logic [7:0] stream [8] = '{8'hff, 8'h00, 8'ha5, 8'h5a, 8'h80, 8'h01, 8'hc3, 8'h3c};
    foreach (stream[i]) issue_request(make_req(REQ_PUSH, stream[i], 1'b0, 6'd0));
    // buffer full: byte dropped, frame end still taken
    issue_request(make_req(REQ_PUSH, 8'h77, 1'b1, 6'd0));
    issue_request(make_req(REQ_GET, 8'h00, 1'b0, 6'd0));
    issue_request(make_req(REQ_PEEK, 8'h00, 1'b0, 6'd32));
    issue_request(make_req(REQ_PEEK_AFTER, 8'h00, 1'b0, 6'd32));
    issue_request(make_req(REQ_GET, 8'h00, 1'b0, 6'd32));
    issue_request(make_req(REQ_GET, 8'h00, 1'b0, 6'd1));
    issue_request(make_req(REQ_PEEK_ALIGN, 8'h00, 1'b0, 6'd0));
    issue_request(make_req(REQ_PEEK, 8'h00, 1'b0, 6'd32));
    wait_results_done();
  endtask

  task automatic test_end_of_data();
    issue_request(make_req(REQ_GET, 8'h00, 1'b0, 6'd32));
    issue_request(make_req(REQ_PEEK, 8'h00, 1'b0, 6'd1));
    issue_request(make_req(REQ_PEEK_ALIGN, 8'h00, 1'b0, 6'd0));
    issue_request(make_req(REQ_PEEK_AFTER, 8'h00, 1'b0, 6'd5));
    issue_request(make_req(REQ_PUSH, 8'hff, 1'b0, 6'd0));
    issue_request(make_req(REQ_RESTART, 8'h00, 1'b0, 6'd0));
    wait_results_done();
    stim_fill = 0;
  endtask

  task automatic test_random(int items, int send_pct, int recv_pct);
    set_idling(send_pct, recv_pct);
    repeat (items) issue_request(random_req());
    wait_results_done();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_asks <= hold_asks + 1;
    repeat (20) issue_request(make_req(REQ_PUSH, 8'($urandom_range(255)), 1'b0, 6'd0));
    repeat (10) issue_request(make_req(REQ_PEEK, 8'h00, 1'b0, COUNT_W'($urandom_range(32))));
    wait_results_done();
    repeat (10) issue_request(random_req());
    wait_results_done();
    stim_fill = pred_fill;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_bad();
    test_fill_and_read();
    test_end_of_data();
    test_backpressure();
    test_random(300, 0, 0);
    test_random(250, 73, 0);
    test_random(250, 0, 73);
    test_random(250, 7, 7);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_rsp.size());
      errors++;
    end
    $display("covered %0d requests and %0d results over four idling phases and a long hold-off",
             req_count, rsp_count);
    $display("statuses seen: ok %0d, end of data %0d, full %0d, bad %0d, starved %0d",
             status_hits[ST_OK], status_hits[ST_EOD], status_hits[ST_FULL],
             status_hits[ST_BAD], status_hits[ST_STARVED]);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
